// ----- sv/mtmt_pkg.sv -----
package mtmt_pkg;

    // Seven-segment words, leftmost digit in the top byte
    localparam logic [31:0] WORD_ASSIST    = 32'h776D_6D78;
    localparam logic [31:0] WORD_DISENGAGE = 32'h5E06_6D79;
    localparam logic [31:0] WORD_BLANK     = 32'h0000_0000;

    // Configuration register indexes
    localparam logic [2:0] REG_FIRST_DEB = 3'd0;
    localparam logic [2:0] REG_TAP_DEB   = 3'd1;
    localparam logic [2:0] REG_WINDOW    = 3'd2;
    localparam logic [2:0] REG_HOLD      = 3'd3;
    localparam logic [2:0] REG_OFF_THR   = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_FIRST_DEB = 16'd100;
    localparam logic [15:0] RST_TAP_DEB   = 16'd50;
    localparam logic [15:0] RST_WINDOW    = 16'd2000;
    localparam logic [15:0] RST_HOLD      = 16'd10000;
    localparam logic [7:0]  RST_OFF_THR   = 8'd3;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;
    localparam logic [7:0]  TAPS_MAX  = 8'hFF;

    // Result beat layout
    typedef struct packed {
        logic [5:0]  pad;
        logic [7:0]  tap_count;
        logic        count_done;
        logic        assist_on;
        logic [31:0] display_word;
    } t_result;

endpackage

// ----- sv/multi_tap_mode_toggle.sv -----
// multi_tap_mode_toggle: tap counter with window timeout, toggles assist mode.
// An accepted input beat reaches its result beat through the input register, then
// the result register.
// Throughput: one beat per cycle; a stalled result beat holds the input off once
// the input register is also full.
// Reset (synchronous, active low): registers return to their defaults, phase idle,
// timer, tap count, assist mode and display cleared, both stages empty.
module multi_tap_mode_toggle (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [31:0] display_word, [32] assist_on,
                                        // [33] count_done, [41:34] tap_count, [47:42] zero
);

    typedef enum logic [2:0] {
        P_IDLE      = 3'd0,
        P_REL_FIRST = 3'd1,
        P_DEB       = 3'd2,
        P_WINDOW    = 3'd3,
        P_REL_TAP   = 3'd4,
        P_HOLD      = 3'd5
    } t_phase;

    // configuration
    logic [15:0] r_first_deb, r_tap_deb, r_window, r_hold;
    logic [7:0]  r_off_thr;

    // state
    t_phase      r_phase, n_phase;
    logic [15:0] r_timer, n_timer;
    logic [7:0]  r_taps, n_taps;
    logic        r_assist, n_assist;
    logic [31:0] r_word, n_word;

    // pipeline
    logic        r_in_valid;
    logic        r_in_pin;
    logic        r_out_valid;
    mtmt_pkg::t_result r_out, n_out;
    logic        advance;
    logic        n_done;
    logic [7:0]  n_count;
    logic [15:0] timer_inc;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_deb <= mtmt_pkg::RST_FIRST_DEB;
            r_tap_deb   <= mtmt_pkg::RST_TAP_DEB;
            r_window    <= mtmt_pkg::RST_WINDOW;
            r_hold      <= mtmt_pkg::RST_HOLD;
            r_off_thr   <= mtmt_pkg::RST_OFF_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mtmt_pkg::REG_FIRST_DEB: r_first_deb <= i_cfg_data;
                mtmt_pkg::REG_TAP_DEB:   r_tap_deb   <= i_cfg_data;
                mtmt_pkg::REG_WINDOW:    r_window    <= i_cfg_data;
                mtmt_pkg::REG_HOLD:      r_hold      <= i_cfg_data;
                mtmt_pkg::REG_OFF_THR:   r_off_thr   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign timer_inc = (r_timer != mtmt_pkg::TIMER_MAX) ? r_timer + 16'd1 : r_timer;

    // per-beat phase update
    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_taps   = r_taps;
        n_assist = r_assist;
        n_word   = r_word;
        n_done   = 1'b0;
        n_count  = 8'd0;
        case (r_phase)
            P_REL_FIRST, P_REL_TAP: begin
                if (!r_in_pin) begin
                    if (r_phase == P_REL_FIRST) begin
                        n_timer = r_first_deb;
                    end else begin
                        n_timer = r_tap_deb;
                    end
                    n_phase = (n_timer == 16'd0) ? P_WINDOW : P_DEB;
                end
            end
            P_DEB: begin
                if (r_timer <= 16'd1) begin
                    n_phase = P_WINDOW;
                    n_timer = 16'd0;
                end else begin
                    n_timer = r_timer - 16'd1;
                end
            end
            P_WINDOW: begin
                if (r_in_pin) begin
                    if (r_taps != mtmt_pkg::TAPS_MAX) begin
                        n_taps = r_taps + 8'd1;
                    end
                    n_phase = P_REL_TAP;
                end else begin
                    n_timer = timer_inc;
                    if (timer_inc >= r_window) begin
                        n_done  = 1'b1;
                        n_count = r_taps;
                        n_phase = P_IDLE;
                        n_timer = 16'd0;
                        if (!r_assist && r_taps < r_off_thr) begin
                            n_assist = 1'b1;
                            n_word   = mtmt_pkg::WORD_ASSIST;
                        end else if (r_assist && r_taps >= r_off_thr) begin
                            n_assist = 1'b0;
                            if (r_hold == 16'd0) begin
                                n_word = mtmt_pkg::WORD_BLANK;
                            end else begin
                                n_word  = mtmt_pkg::WORD_DISENGAGE;
                                n_phase = P_HOLD;
                                n_timer = r_hold;
                            end
                        end
                    end
                end
            end
            P_HOLD: begin
                if (r_timer <= 16'd1) begin
                    n_word  = mtmt_pkg::WORD_BLANK;
                    n_phase = P_IDLE;
                    n_timer = 16'd0;
                end else begin
                    n_timer = r_timer - 16'd1;
                end
            end
            default: begin
                n_phase = P_IDLE;
                n_timer = 16'd0;
                if (r_in_pin) begin
                    n_taps  = 8'd1;
                    n_phase = P_REL_FIRST;
                end
            end
        endcase

        n_out              = '0;
        n_out.display_word = n_word;
        n_out.assist_on    = n_assist;
        n_out.count_done   = n_done;
        n_out.tap_count    = n_count;
    end

    // input register, state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= P_IDLE;
            r_timer     <= 16'd0;
            r_taps      <= 8'd0;
            r_assist    <= 1'b0;
            r_word      <= mtmt_pkg::WORD_BLANK;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
                r_in_pin   <= s_axis_tdata[0];
            end
            if (advance) begin
                r_phase     <= n_phase;
                r_timer     <= n_timer;
                r_taps      <= n_taps;
                r_assist    <= n_assist;
                r_word      <= n_word;
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // the hold phase only follows a disengage
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == P_HOLD |-> (!r_assist && r_word == mtmt_pkg::WORD_DISENGAGE))
        else $error("hold phase without disengage word");

    // a tap count is live whenever a press sequence is in progress
    a_taps_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_REL_FIRST || r_phase == P_DEB || r_phase == P_WINDOW ||
         r_phase == P_REL_TAP) |-> r_taps != 8'd0)
        else $error("tap sequence with zero taps");

    // a window close leaves the block idle or holding
    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_done) |=> (r_phase == P_IDLE || r_phase == P_HOLD))
        else $error("window closed into wrong phase");

    // state only moves when a beat is processed
    a_state_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_phase) && $stable(r_timer) && $stable(r_taps)))
        else $error("state changed without a beat");

endmodule

// ----- tb/sv/multi_tap_mode_toggle_tb.sv -----
`timescale 1ns / 100ps

module multi_tap_mode_toggle_tb;

    localparam int STUCK_LIMIT  = 2000;
    localparam int LONG_STALL   = 80;
    localparam int PHASE_PINS   = 60;
    localparam int MAX_REPORTED = 10;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_REL_FIRST = 3'd1,
        PH_DEBOUNCE  = 3'd2,
        PH_WINDOW    = 3'd3,
        PH_REL_TAP   = 3'd4,
        PH_HOLD      = 3'd5
    } tap_phase_e;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_idx     = '0;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    multi_tap_mode_toggle dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [0] pin_level, [7:1] zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [31:0] display_word, [32] assist_on,
                                         // [33] count_done, [41:34] tap_count
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the configuration
    logic [15:0] c_first_deb = mtmt_pkg::RST_FIRST_DEB;
    logic [15:0] c_tap_deb   = mtmt_pkg::RST_TAP_DEB;
    logic [15:0] c_window    = mtmt_pkg::RST_WINDOW;
    logic [15:0] c_hold      = mtmt_pkg::RST_HOLD;
    logic [7:0]  c_off_thr   = mtmt_pkg::RST_OFF_THR;

    // Predicted tap detector state
    tap_phase_e  tap_phase      = PH_IDLE;
    logic [15:0] tap_timer      = '0;
    logic [7:0]  tap_tally      = '0;
    logic        assist_engaged = 1'b0;
    logic [31:0] shown_word     = mtmt_pkg::WORD_BLANK;

    bit                pin_fifo[$];
    mtmt_pkg::t_result tick_expect_q[$];
    int      pins_pushed;
    int      idle_pct = 0;
    int      err_count = 0;
    int      beats_seen = 0;
    int      stuck_cycles = 0;
    int      tx_gap_left = 0;
    int      rx_stall_left = 0;
    bit      rx_hold_tgl = 1'b0;
    bit      rx_hold_seen = 1'b0;
    bit      in_taken = 1'b0;
    mtmt_pkg::t_result seen_beat;
    mtmt_pkg::t_result want_beat;

    // Debounce of zero opens the window on the release tick
    function automatic void open_debounce(input logic [15:0] ticks);
        if (ticks == 16'd0) begin
            tap_phase = PH_WINDOW;
            tap_timer = '0;
        end else begin
            tap_phase = PH_DEBOUNCE;
            tap_timer = ticks;
        end
    endfunction

    // One sampling tick of the tap detector; returns the beat it produces
    function automatic mtmt_pkg::t_result predict_tick(input logic pin);
        mtmt_pkg::t_result r;
        logic       closed;
        logic [7:0] closed_taps;
        closed      = 1'b0;
        closed_taps = '0;
        case (tap_phase)
            PH_REL_FIRST: begin
                if (!pin) open_debounce(c_first_deb);
            end
            PH_DEBOUNCE: begin
                if (tap_timer <= 16'd1) begin
                    tap_phase = PH_WINDOW;
                    tap_timer = '0;
                end else begin
                    tap_timer = tap_timer - 16'd1;
                end
            end
            PH_WINDOW: begin
                if (pin) begin
                    if (tap_tally != mtmt_pkg::TAPS_MAX) tap_tally = tap_tally + 8'd1;
                    tap_phase = PH_REL_TAP;
                end else begin
                    if (tap_timer != mtmt_pkg::TIMER_MAX) tap_timer = tap_timer + 16'd1;
                    if (tap_timer >= c_window) begin
                        closed      = 1'b1;
                        closed_taps = tap_tally;
                        tap_phase   = PH_IDLE;
                        tap_timer   = '0;
                        if (!assist_engaged && tap_tally < c_off_thr) begin
                            assist_engaged = 1'b1;
                            shown_word     = mtmt_pkg::WORD_ASSIST;
                        end else if (assist_engaged && tap_tally >= c_off_thr) begin
                            assist_engaged = 1'b0;
                            shown_word     = mtmt_pkg::WORD_DISENGAGE;
                            if (c_hold == 16'd0) begin
                                shown_word = mtmt_pkg::WORD_BLANK;
                            end else begin
                                tap_phase = PH_HOLD;
                                tap_timer = c_hold;
                            end
                        end
                    end
                end
            end
            PH_REL_TAP: begin
                if (!pin) open_debounce(c_tap_deb);
            end
            PH_HOLD: begin
                // pin ignored until the hold runs out
                if (tap_timer <= 16'd1) begin
                    shown_word = mtmt_pkg::WORD_BLANK;
                    tap_phase  = PH_IDLE;
                    tap_timer  = '0;
                end else begin
                    tap_timer = tap_timer - 16'd1;
                end
            end
            default: begin
                tap_phase = PH_IDLE;
                tap_timer = '0;
                if (pin) begin
                    tap_tally = 8'd1;
                    tap_phase = PH_REL_FIRST;
                end
            end
        endcase
        r              = '0;
        r.display_word = shown_word;
        r.assist_on    = assist_engaged;
        r.count_done   = closed;
        r.tap_count    = closed_taps;
        return r;
    endfunction

    // Input driver: changes on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (tx_gap_left > 0) begin
                tx_gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pin_fifo.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                tx_gap_left = $urandom_range(0, 3);
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tdata  <= {7'd0, pin_fifo.pop_front()};
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Result receiver: random stall bursts, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold_tgl != rx_hold_seen) begin
            rx_hold_seen  = rx_hold_tgl;
            rx_stall_left = LONG_STALL - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rx_stall_left = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Predict on each accepted input beat, check each accepted result beat
    always @(posedge i_clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            tick_expect_q.push_back(predict_tick(s_axis_tdata[0]));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_beat = m_axis_tdata;
            beats_seen++;
            if (tick_expect_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTED)
                    $display("result beat %0d with nothing expected: %h", beats_seen,
                             m_axis_tdata);
            end else begin
                want_beat = tick_expect_q.pop_front();
                if (seen_beat.display_word !== want_beat.display_word ||
                    seen_beat.assist_on    !== want_beat.assist_on    ||
                    seen_beat.count_done   !== want_beat.count_done   ||
                    seen_beat.tap_count    !== want_beat.tap_count) begin
                    err_count++;
                    if (err_count <= MAX_REPORTED)
                        $display({"beat %0d mismatch: want word %h assist %b done %b taps %0d,",
                                  " got word %h assist %b done %b taps %0d"}, beats_seen,
                                 want_beat.display_word, want_beat.assist_on,
                                 want_beat.count_done, want_beat.tap_count,
                                 seen_beat.display_word, seen_beat.assist_on,
                                 seen_beat.count_done, seen_beat.tap_count);
                end
            end
        end
    end

    // Watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("multi_tap_mode_toggle_tb: errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic void push_pin(input bit v);
        pin_fifo.push_back(v);
        pins_pushed++;
    endfunction

    // Well-formed gesture of n taps sized to the current settings
    function automatic void push_gesture(input int n, input int max_press);
        int wmax;
        wmax = (c_window > 16'd1) ? int'(c_window) - 1 : 0;
        for (int t = 0; t < n; t++) begin
            repeat ($urandom_range(1, max_press)) push_pin(1'b1);
            push_pin(1'b0);
            // debounce ticks: pin content does not matter
            repeat ((t == 0) ? int'(c_first_deb) : int'(c_tap_deb))
                push_pin(1'($urandom_range(0, 1)));
            if (t < n - 1) repeat ($urandom_range(0, wmax)) push_pin(1'b0);
        end
        repeat ((c_window > 16'd1) ? int'(c_window) : 1) push_pin(1'b0);
        repeat (int'(c_hold)) push_pin($urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 2)) push_pin(1'b0);
    endfunction

    // Enough low ticks to bring any phase back to idle
    function automatic void push_settle();
        repeat (int'(c_first_deb) + int'(c_tap_deb) + int'(c_window) + int'(c_hold) + 3)
            push_pin(1'b0);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            mtmt_pkg::REG_FIRST_DEB: c_first_deb = data;
            mtmt_pkg::REG_TAP_DEB:   c_tap_deb   = data;
            mtmt_pkg::REG_WINDOW:    c_window    = data;
            mtmt_pkg::REG_HOLD:      c_hold      = data;
            mtmt_pkg::REG_OFF_THR:   c_off_thr   = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] fd, input logic [15:0] td,
                             input logic [15:0] w, input logic [15:0] h, input int thr);
        write_reg(mtmt_pkg::REG_FIRST_DEB, fd);
        write_reg(mtmt_pkg::REG_TAP_DEB, td);
        write_reg(mtmt_pkg::REG_WINDOW, w);
        write_reg(mtmt_pkg::REG_HOLD, h);
        // upper byte of the threshold write is junk
        write_reg(mtmt_pkg::REG_OFF_THR, 16'(($urandom_range(0, 255) << 8) | thr));
    endtask

    // Wait for every beat to be sent and answered, then let the pipe settle
    task automatic wait_drained();
        @(posedge i_clk);
        while (pin_fifo.size() != 0 || s_axis_tvalid || tick_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_list(input bit pins[]);
        foreach (pins[i]) push_pin(pins[i]);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a press left waiting for release
        idle_pct = 20;
        push_list('{1'b0, 1'b1, 1'b1});
        wait_drained();

        // All registers at their maximum; still waiting for release
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 255);
        push_list('{1'b1, 1'b1});
        wait_drained();

        // All zero: release opens the window at once, first idle tick closes it,
        // threshold zero means nothing ever engages; bad indexes are ignored
        write_all(16'd0, 16'd0, 16'd0, 16'd0, 0);
        write_reg(3'd5, 16'hFFFF);
        write_reg(3'd6, 16'h0001);
        write_reg(3'd7, 16'h0003);
        push_list('{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0});
        wait_drained();

        // One tap engages, two taps disengage with no hold
        write_reg(mtmt_pkg::REG_OFF_THR, 16'd2);
        push_list('{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0});
        wait_drained();

        // Pin ignored during debounce; high threshold engages
        write_all(16'd2, 16'd1, 16'd2, 16'd3, 255);
        push_list('{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0});
        wait_drained();

        // Low threshold disengages; presses during the hold are ignored
        write_reg(mtmt_pkg::REG_OFF_THR, 16'd1);
        push_list('{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0});
        wait_drained();

        // Tap counter saturation: more than 255 single-tick taps
        write_all(16'd0, 16'd0, 16'd1, 16'd2, 255);
        push_gesture(258, 1);
        wait_drained();

        // Random settings and gestures
        for (int p = 0; p < 6; p++) begin
            write_all(16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
                      ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 6)),
                      16'($urandom_range(0, 6)),
                      ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 5)));
            if (p == 5) idle_pct = 0;
            else if (p == 1) idle_pct = 20;
            else idle_pct = $urandom_range(0, 2) * 15;
            pins_pushed = 0;
            while (pins_pushed < PHASE_PINS) begin
                if ($urandom_range(0, 9) < 8) begin
                    push_gesture($urandom_range(1, int'(c_off_thr) + 2), 3);
                end else begin
                    repeat ($urandom_range(3, 12)) push_pin(1'($urandom_range(0, 1)));
                    push_settle();
                end
            end
            // long receiver hold-off while the sender keeps offering beats
            if (p == 1) rx_hold_tgl = ~rx_hold_tgl;
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (err_count == 0 && tick_expect_q.size() == 0) begin
            $display("multi_tap_mode_toggle_tb: clean");
        end else begin
            $display("multi_tap_mode_toggle_tb: errors");
        end
        $finish;
    end

endmodule
